@@ rtl/image_convolution_3x3_macros.svh @@
// Assertion macros for the 3x3 convolution block.
// Used by the top level; expects clk_i and rst_ni in scope.
`ifndef IMAGE_CONVOLUTION_3X3_MACROS_SVH
`define IMAGE_CONVOLUTION_3X3_MACROS_SVH

// Same-cycle implication.
`define IC3_ASSERT_NOW(label, ante, cons, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication.
`define IC3_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

@@ rtl/ic3_pkg.sv @@
// Shared types and constants for the 3x3 convolution block.
// No dependencies.
package ic3_pkg;

  localparam int MaxWidthDef  = 1024;
  localparam int MaxHeightDef = 1024;
  localparam int CfgIdxW      = 3;
  localparam int CfgDataW     = 48;
  localparam int CoefW        = 16;
  localparam int AccW         = 28;
  localparam int WsumW        = 20;
  localparam int QuotW        = 8;
  localparam int StepW        = 3;
  localparam int NumChan      = 3;

  typedef enum logic {
    CMD_PIXEL = 1'b0,
    CMD_DRAIN = 1'b1
  } cmd_e;

  typedef enum logic [CfgIdxW-1:0] {
    CFG_COEF_TOP    = 3'd0,
    CFG_COEF_MID    = 3'd1,
    CFG_COEF_BOTTOM = 3'd2,
    CFG_WIDTH       = 3'd3,
    CFG_HEIGHT      = 3'd4,
    CFG_GRAY        = 3'd5
  } cfg_idx_e;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_MAC,
    ST_FLUSH,
    ST_PREP,
    ST_DIV,
    ST_LOAD
  } state_e;

  typedef struct packed {
    cmd_e       command;
    logic [7:0] red_in;
    logic [7:0] green_in;
    logic [7:0] blue_in;
  } in_item_t;

  typedef struct packed {
    logic [7:0] red_out;
    logic [7:0] green_out;
    logic [7:0] blue_out;
    logic       frame_end;
  } out_item_t;

  typedef struct packed {
    logic       take;
    logic       rd;
    logic [1:0] ty;
    logic [1:0] tx;
    logic       prep;
    logic       step;
    logic       load;
  } ctrl_cmd_t;

  typedef struct packed {
    logic emit_req;
    logic out_free;
  } ctrl_stat_t;

endpackage

@@ rtl/image_convolution_3x3.sv @@
// Top level of the 3x3 RGB convolution block.
// Depends on ic3_pkg, ic3_ctrl, ic3_dp and image_convolution_3x3_macros.svh.
//
//   channel  direction  signals                        beat
//   in       input      in_valid_i/in_ready_o          in_data_i (pixel or drain)
//   out      output     out_valid_o/out_ready_i        out_data_o (filtered pixel)
//   cfg      input      cfg_valid_i/cfg_ready_o        cfg_index_i, cfg_data_i
//
// A beat that yields no result leaves the block idle. A beat that yields a result
// runs nine taps through the single line-ring read port, one drain state, one
// setup and eight restoring divide steps, and one load into the output register.
// No clearing pass after reset. A held output stalls only the load step.
`include "image_convolution_3x3_macros.svh"

module image_convolution_3x3 #(
  parameter int MAX_WIDTH  = ic3_pkg::MaxWidthDef,
  parameter int MAX_HEIGHT = ic3_pkg::MaxHeightDef
) (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         in_valid_i,
  output logic                         in_ready_o,
  input  ic3_pkg::in_item_t            in_data_i,
  output logic                         out_valid_o,
  input  logic                         out_ready_i,
  output ic3_pkg::out_item_t           out_data_o,
  input  logic                         cfg_valid_i,
  output logic                         cfg_ready_o,
  input  logic [ic3_pkg::CfgIdxW-1:0]  cfg_index_i,
  input  logic [ic3_pkg::CfgDataW-1:0] cfg_data_i
);

  ic3_pkg::ctrl_cmd_t  cmd;
  ic3_pkg::ctrl_stat_t stat;

  assign cfg_ready_o = 1'b1;

  ic3_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_ready_o (in_ready_o),
    .stat_i     (stat),
    .cmd_o      (cmd)
  );

  ic3_dp #(
    .MAX_WIDTH  (MAX_WIDTH),
    .MAX_HEIGHT (MAX_HEIGHT)
  ) u_dp (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_valid_i (cfg_valid_i),
    .cfg_index_i (cfg_index_i),
    .cfg_data_i  (cfg_data_i),
    .in_data_i   (in_data_i),
    .cmd_i       (cmd),
    .stat_o      (stat),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .out_data_o  (out_data_o)
  );

  `IC3_ASSERT_NOW(a_load_free, cmd.load, stat.out_free, "load into occupied output")
  `IC3_ASSERT_NEXT(a_load_valid, cmd.load, out_valid_o, "loaded result not presented")
  `IC3_ASSERT_NEXT(a_no_emit_idle, cmd.take && !stat.emit_req, in_ready_o, "stuck after no-result beat")
  `IC3_ASSERT_NOW(a_rd_busy, cmd.rd, !in_ready_o, "input taken during tap reads")

endmodule

@@ rtl/ic3_ram.sv @@
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
module ic3_ram #(
  parameter int WIDTH = 24,
  parameter int DEPTH = 4096
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_q <= mem_q[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

@@ rtl/ic3_ctrl.sv @@
// Sequencer for the 3x3 convolution: accept, nine-tap MAC, divide, load.
// Depends on ic3_pkg.
module ic3_ctrl (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  in_valid_i,
  output logic                  in_ready_o,
  input  ic3_pkg::ctrl_stat_t   stat_i,
  output ic3_pkg::ctrl_cmd_t    cmd_o
);

  localparam logic [1:0] TapLast = 2'd2;
  localparam logic [ic3_pkg::StepW-1:0] StepLast = ic3_pkg::StepW'(ic3_pkg::QuotW - 1);

  ic3_pkg::state_e state_q, state_d;
  logic [1:0] ty_q, ty_d, tx_q, tx_d;
  logic [ic3_pkg::StepW-1:0] step_q, step_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ic3_pkg::ST_IDLE;
      ty_q    <= '0;
      tx_q    <= '0;
      step_q  <= '0;
    end else begin
      state_q <= state_d;
      ty_q    <= ty_d;
      tx_q    <= tx_d;
      step_q  <= step_d;
    end
  end

  always_comb begin
    state_d    = state_q;
    ty_d       = ty_q;
    tx_d       = tx_q;
    step_d     = step_q;
    in_ready_o = 1'b0;
    cmd_o      = '0;
    unique case (state_q)
      ic3_pkg::ST_IDLE: begin
        in_ready_o = 1'b1;
        if (in_valid_i) begin
          cmd_o.take = 1'b1;
          if (stat_i.emit_req) begin
            state_d = ic3_pkg::ST_MAC;
            ty_d    = '0;
            tx_d    = '0;
          end
        end
      end
      ic3_pkg::ST_MAC: begin
        cmd_o.rd = 1'b1;
        cmd_o.ty = ty_q;
        cmd_o.tx = tx_q;
        if (tx_q == TapLast) begin
          tx_d = '0;
          if (ty_q == TapLast) begin
            state_d = ic3_pkg::ST_FLUSH;
          end else begin
            ty_d = ty_q + 2'd1;
          end
        end else begin
          tx_d = tx_q + 2'd1;
        end
      end
      ic3_pkg::ST_FLUSH: begin
        state_d = ic3_pkg::ST_PREP;
      end
      ic3_pkg::ST_PREP: begin
        cmd_o.prep = 1'b1;
        step_d     = '0;
        state_d    = ic3_pkg::ST_DIV;
      end
      ic3_pkg::ST_DIV: begin
        cmd_o.step = 1'b1;
        step_d     = step_q + 1'b1;
        if (step_q == StepLast) begin
          state_d = ic3_pkg::ST_LOAD;
        end
      end
      ic3_pkg::ST_LOAD: begin
        if (stat_i.out_free) begin
          cmd_o.load = 1'b1;
          state_d    = ic3_pkg::ST_IDLE;
        end
      end
      default: begin
        state_d = ic3_pkg::ST_IDLE;
      end
    endcase
  end

endmodule

@@ rtl/ic3_dp.sv @@
// Datapath for the 3x3 convolution: config, counters, line ring, MAC, divider, output register.
// Depends on ic3_pkg and ic3_ram.
module ic3_dp #(
  parameter int MAX_WIDTH  = ic3_pkg::MaxWidthDef,
  parameter int MAX_HEIGHT = ic3_pkg::MaxHeightDef
) (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic                            cfg_valid_i,
  input  logic [ic3_pkg::CfgIdxW-1:0]     cfg_index_i,
  input  logic [ic3_pkg::CfgDataW-1:0]    cfg_data_i,
  input  ic3_pkg::in_item_t               in_data_i,
  input  ic3_pkg::ctrl_cmd_t              cmd_i,
  output ic3_pkg::ctrl_stat_t             stat_o,
  output logic                            out_valid_o,
  input  logic                            out_ready_i,
  output ic3_pkg::out_item_t              out_data_o
);

  localparam int CW    = $clog2(MAX_WIDTH);
  localparam int RW    = $clog2(MAX_HEIGHT);
  localparam int WW    = $clog2(MAX_WIDTH + 1);
  localparam int HW    = $clog2(MAX_HEIGHT + 1);
  localparam int XW0   = (WW > HW) ? WW : HW;
  localparam int XW    = ((XW0 > 11) ? XW0 : 11) + 1;
  localparam int PW    = $clog2(MAX_WIDTH + 3);
  localparam int RAM_D = 4 * (2 ** CW);
  localparam int AW    = $clog2(RAM_D);
  localparam int ACC   = ic3_pkg::AccW;
  localparam int WS    = ic3_pkg::WsumW;
  localparam int NC    = ic3_pkg::NumChan;

  // configuration
  logic [ic3_pkg::CfgDataW-1:0] coef_q [3];
  logic [10:0] width_q, height_q;
  logic        gray_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      coef_q[0] <= '0;
      coef_q[1] <= ic3_pkg::CfgDataW'(48'h0000_0100_0000);
      coef_q[2] <= '0;
      width_q   <= 11'd1024;
      height_q  <= 11'd1024;
      gray_q    <= 1'b0;
    end else if (cfg_valid_i) begin
      unique case (ic3_pkg::cfg_idx_e'(cfg_index_i))
        ic3_pkg::CFG_COEF_TOP:    coef_q[0] <= cfg_data_i;
        ic3_pkg::CFG_COEF_MID:    coef_q[1] <= cfg_data_i;
        ic3_pkg::CFG_COEF_BOTTOM: coef_q[2] <= cfg_data_i;
        ic3_pkg::CFG_WIDTH:       width_q   <= cfg_data_i[10:0];
        ic3_pkg::CFG_HEIGHT:      height_q  <= cfg_data_i[10:0];
        ic3_pkg::CFG_GRAY:        gray_q    <= cfg_data_i[0];
        default: ;
      endcase
    end
  end

  logic [XW-1:0] w_x, h_x;
  always_comb begin
    if (width_q == '0) begin
      w_x = XW'(1);
    end else if (XW'(width_q) > XW'(MAX_WIDTH)) begin
      w_x = XW'(MAX_WIDTH);
    end else begin
      w_x = XW'(width_q);
    end
    if (height_q == '0) begin
      h_x = XW'(1);
    end else if (XW'(height_q) > XW'(MAX_HEIGHT)) begin
      h_x = XW'(MAX_HEIGHT);
    end else begin
      h_x = XW'(height_q);
    end
  end

  // position counters
  logic [CW-1:0] in_col_q, out_col_q;
  logic [RW-1:0] out_row_q;
  logic [1:0]    in_slot_q, out_slot_q;
  logic [PW-1:0] pend_q;

  logic in_col_last, out_col_last, out_row_last;
  logic [XW-1:0] need;
  logic is_pixel;

  assign is_pixel     = (in_data_i.command == ic3_pkg::CMD_PIXEL);
  assign in_col_last  = (XW'(in_col_q) + XW'(1)) >= w_x;
  assign out_col_last = (XW'(out_col_q) + XW'(1)) >= w_x;
  assign out_row_last = (XW'(out_row_q) + XW'(1)) >= h_x;
  assign need = (out_row_last ? '0 : w_x) + (out_col_last ? '0 : XW'(1));

  assign stat_o.emit_req = is_pixel ? (XW'(pend_q) > w_x) : (XW'(pend_q) > need);

  logic out_valid_q;
  assign stat_o.out_free = !out_valid_q || out_ready_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_col_q   <= '0;
      in_slot_q  <= '0;
      out_col_q  <= '0;
      out_row_q  <= '0;
      out_slot_q <= '0;
      pend_q     <= '0;
    end else begin
      if (cmd_i.take && is_pixel) begin
        pend_q <= pend_q + 1'b1;
        if (in_col_last) begin
          in_col_q  <= '0;
          in_slot_q <= in_slot_q + 2'd1;
        end else begin
          in_col_q <= in_col_q + 1'b1;
        end
      end
      if (cmd_i.load) begin
        pend_q <= pend_q - 1'b1;
        if (out_col_last) begin
          out_col_q  <= '0;
          out_slot_q <= out_slot_q + 2'd1;
          out_row_q  <= out_row_last ? '0 : out_row_q + 1'b1;
        end else begin
          out_col_q <= out_col_q + 1'b1;
        end
      end
    end
  end

  // tap address and coefficient
  logic [1:0]    rd_slot;
  logic [XW-1:0] col_x, col_c;
  logic [ic3_pkg::CfgDataW-1:0] coef_row;
  logic signed [ic3_pkg::CoefW-1:0] coef_sel;

  always_comb begin
    unique case (cmd_i.ty)
      2'd0:    rd_slot = (out_row_q != '0) ? out_slot_q - 2'd1 : out_slot_q;
      2'd2:    rd_slot = out_row_last ? out_slot_q : out_slot_q + 2'd1;
      default: rd_slot = out_slot_q;
    endcase
    unique case (cmd_i.tx)
      2'd0:    col_x = (out_col_q == '0) ? '0 : XW'(out_col_q) - XW'(1);
      2'd2:    col_x = XW'(out_col_q) + XW'(1);
      default: col_x = XW'(out_col_q);
    endcase
    col_c = (col_x > w_x - XW'(1)) ? w_x - XW'(1) : col_x;
    // mask is flipped: tap (ty,tx) uses coefficient (2-ty, 2-tx)
    unique case (cmd_i.ty)
      2'd0:    coef_row = coef_q[2];
      2'd2:    coef_row = coef_q[0];
      default: coef_row = coef_q[1];
    endcase
    unique case (cmd_i.tx)
      2'd0:    coef_sel = coef_row[47:32];
      2'd2:    coef_sel = coef_row[15:0];
      default: coef_sel = coef_row[31:16];
    endcase
  end

  logic [23:0] rdata;

  ic3_ram #(
    .WIDTH (24),
    .DEPTH (RAM_D)
  ) u_ring (
    .clk_i   (clk_i),
    .we_i    (cmd_i.take && is_pixel),
    .waddr_i ({in_slot_q, in_col_q}),
    .wdata_i ({in_data_i.blue_in, in_data_i.green_in, in_data_i.red_in}),
    .raddr_i (AW'({rd_slot, col_c[CW-1:0]})),
    .rdata_o (rdata)
  );

  // multiply-accumulate
  logic mac_v_q;
  logic signed [ic3_pkg::CoefW-1:0] coef_q1;
  logic signed [ACC-1:0] acc_q [NC];
  logic signed [WS-1:0]  wsum_q;
  logic signed [24:0]    prod [NC];

  always_comb begin
    for (int c = 0; c < NC; c++) begin
      prod[c] = $signed({1'b0, rdata[8*c +: 8]}) * coef_q1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mac_v_q <= 1'b0;
    end else begin
      mac_v_q <= cmd_i.rd;
    end
  end

  always_ff @(posedge clk_i) begin
    coef_q1 <= coef_sel;
    if (cmd_i.take) begin
      wsum_q <= '0;
      for (int c = 0; c < NC; c++) begin
        acc_q[c] <= '0;
      end
    end else if (mac_v_q) begin
      wsum_q <= wsum_q + WS'(coef_q1);
      for (int c = 0; c < NC; c++) begin
        acc_q[c] <= acc_q[c] + ACC'(prod[c]);
      end
    end
  end

  // divider: clamp flags, then eight restoring steps per channel
  logic [WS-1:0]  dvs;
  logic [ACC-1:0] dsh_q;
  logic [ACC-1:0] rem_q [NC];
  logic [ic3_pkg::QuotW-1:0] quo_q [NC];
  logic [NC-1:0]  zero_q, sat_q;
  logic [ACC-1:0] mag [NC];

  always_comb begin
    if (wsum_q == '0) begin
      dvs = WS'(256);
    end else if (wsum_q[WS-1]) begin
      dvs = WS'(-wsum_q);
    end else begin
      dvs = WS'(wsum_q);
    end
    for (int c = 0; c < NC; c++) begin
      mag[c] = acc_q[c][ACC-1] ? ACC'(-acc_q[c]) : ACC'(acc_q[c]);
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.prep) begin
      dsh_q <= ACC'({dvs, 7'b0});
      for (int c = 0; c < NC; c++) begin
        rem_q[c]  <= mag[c];
        quo_q[c]  <= '0;
        zero_q[c] <= acc_q[c][ACC-1] ^ wsum_q[WS-1];
        sat_q[c]  <= mag[c] >= ACC'({dvs, 8'b0});
      end
    end else if (cmd_i.step) begin
      dsh_q <= dsh_q >> 1;
      for (int c = 0; c < NC; c++) begin
        if (rem_q[c] >= dsh_q) begin
          rem_q[c] <= rem_q[c] - dsh_q;
          quo_q[c] <= {quo_q[c][ic3_pkg::QuotW-2:0], 1'b1};
        end else begin
          quo_q[c] <= {quo_q[c][ic3_pkg::QuotW-2:0], 1'b0};
        end
      end
    end
  end

  logic [7:0] res [NC];
  always_comb begin
    for (int c = 0; c < NC; c++) begin
      res[c] = zero_q[c] ? 8'd0 : (sat_q[c] ? 8'd255 : quo_q[c]);
    end
  end

  // output register
  ic3_pkg::out_item_t out_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (cmd_i.load) begin
      out_valid_q <= 1'b1;
    end else if (out_ready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      out_q.red_out   <= res[0];
      out_q.green_out <= gray_q ? 8'd0 : res[1];
      out_q.blue_out  <= gray_q ? 8'd0 : res[2];
      out_q.frame_end <= out_row_last && out_col_last;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

endmodule
